// File: design/lre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lre_pkg
// Shared types, constants and the sequencer control store for the layout
// repetition expander.
// ----------------------------------------------------------------------------
package lre_pkg;

    localparam int MAX_COPIES   = 64;
    localparam int OFFSET_DEPTH = 64;
    localparam int OFF_AW       = (OFFSET_DEPTH > 1) ? $clog2(OFFSET_DEPTH) : 1;
    localparam int CNT_W        = 7;
    localparam int TOTAL_W      = 2 * CNT_W;
    localparam int PC_W         = 3;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_DESC  = 2'd1;
    localparam logic [1:0] FUNC_PLACE = 2'd2;

    localparam logic [3:0] KIND_MATRIX    = 4'd0;
    localparam logic [3:0] KIND_UNIF_X    = 4'd1;
    localparam logic [3:0] KIND_UNIF_Y    = 4'd2;
    localparam logic [3:0] KIND_VARY_X    = 4'd3;
    localparam logic [3:0] KIND_VARY_Y    = 4'd4;
    localparam logic [3:0] KIND_TILTED    = 4'd5;
    localparam logic [3:0] KIND_DIAGONAL  = 4'd6;
    localparam logic [3:0] KIND_ARBITRARY = 4'd7;

    // sequencer step addresses
    localparam logic [PC_W-1:0] PC_IDLE    = 3'd0;
    localparam logic [PC_W-1:0] PC_DECODE  = 3'd1;
    localparam logic [PC_W-1:0] PC_CHECK   = 3'd2;
    localparam logic [PC_W-1:0] PC_LATTICE = 3'd3;
    localparam logic [PC_W-1:0] PC_SINGLE  = 3'd4;
    localparam logic [PC_W-1:0] PC_ERROR   = 3'd5;

    // output word source
    localparam logic [1:0] SRC_NONE    = 2'd0;
    localparam logic [1:0] SRC_INPUT   = 2'd1;
    localparam logic [1:0] SRC_ERROR   = 2'd2;
    localparam logic [1:0] SRC_LATTICE = 2'd3;

    // jump conditions
    localparam logic [2:0] JMP_ALWAYS   = 3'd0;
    localparam logic [2:0] JMP_ON_IN    = 3'd1;
    localparam logic [2:0] JMP_ON_FUNC  = 3'd2;
    localparam logic [2:0] JMP_ON_CHECK = 3'd3;
    localparam logic [2:0] JMP_ON_OUT   = 3'd4;
    localparam logic [2:0] JMP_ON_LAST  = 3'd5;

    typedef struct packed {
        logic [1:0]        func;
        logic [3:0]        rep_kind;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic [6:0]        count_a;
        logic [6:0]        count_b;
        logic [30:0]       rect_width;
        logic [30:0]       rect_height;
        logic [15:0]       layer_num;
        logic              has_rep;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic [30:0]       out_width;
        logic [30:0]       out_height;
        logic [15:0]       out_layer;
        logic              last;
        logic              error;
    } out_word_t;

    typedef struct packed {
        logic            take_in;
        logic            decode;
        logic [1:0]      src;
        logic [2:0]      jmp;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t cw;
        cw = '{take_in: 1'b0, decode: 1'b0, src: SRC_NONE, jmp: JMP_ALWAYS,
               target: PC_IDLE};
        unique case (pc)
            PC_IDLE:
            begin
                cw.take_in = 1'b1;
                cw.jmp     = JMP_ON_IN;
                cw.target  = PC_DECODE;
            end
            PC_DECODE:
            begin
                cw.decode = 1'b1;
                cw.jmp    = JMP_ON_FUNC;
            end
            PC_CHECK:
            begin
                cw.jmp = JMP_ON_CHECK;
            end
            PC_LATTICE:
            begin
                cw.src = SRC_LATTICE;
                cw.jmp = JMP_ON_LAST;
            end
            PC_SINGLE:
            begin
                cw.src = SRC_INPUT;
                cw.jmp = JMP_ON_OUT;
            end
            PC_ERROR:
            begin
                cw.src = SRC_ERROR;
                cw.jmp = JMP_ON_OUT;
            end
            default:
            begin
                cw.jmp = JMP_ALWAYS;
            end
        endcase
        return cw;
    endfunction

endpackage
`default_nettype wire

// File: design/layout_repetition_expander_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// layout_repetition_expander_top
// Expands a placed rectangle into one output word per lattice copy.
// ----------------------------------------------------------------------------
// One word is taken at a time. Loads and descriptor writes end after the
// decode step; a single placement adds the single step, and a placement
// with repetition the check and lattice steps, one copy per cycle while
// the output is not stalled (set by the sequencer's emit step and the
// offset RAM read that runs one copy ahead). Copies of a matrix leave
// outer index first; a bad or missing descriptor gives one error word.
// The output register lets the next word be taken while the last copy waits.
// ----------------------------------------------------------------------------
module layout_repetition_expander_top
    import lre_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      rect_valid,
    output logic           rect_stall,
    input  wire in_word_t  rect_word,
    output logic           copy_valid,
    input  wire logic      copy_stall,
    output out_word_t      copy_word
);

    logic [PC_W-1:0]    pc_reg, pc_next;
    ctrl_word_t         ctrl;
    in_word_t           in_reg;

    logic [2:0]         kind_reg;
    logic               desc_valid_reg;
    logic [CNT_W-1:0]   dim_a_reg, dim_b_reg;
    logic [31:0]        step_a_x_reg, step_a_y_reg, step_b_x_reg, step_b_y_reg;

    logic [CNT_W-1:0]   na_reg, nb_reg, i_reg, j_reg, i_next, j_next, rd_idx;
    logic [TOTAL_W-1:0] total_reg;
    logic [31:0]        os_x_reg, os_y_reg, is_x_reg, is_y_reg;
    logic [31:0]        row_x_reg, row_y_reg, pos_x_reg, pos_y_reg;
    logic               tab_x_reg, tab_y_reg;

    out_word_t          out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic               in_fire, out_free, load_out, lattice_fire;
    logic               row_end, lat_last, tab_ok;
    logic [3:0]         pkind;
    logic [CNT_W-1:0]   nb_sel;
    logic               ram_we;
    logic [63:0]        ram_rdata;
    logic [31:0]        lat_x, lat_y;

    assign ctrl       = ucode_rom(pc_reg);
    assign rect_stall = !ctrl.take_in;
    assign in_fire    = rect_valid && !rect_stall;
    assign out_free   = !out_valid_reg || !copy_stall;
    assign load_out   = (ctrl.src != SRC_NONE) && out_free;
    assign lattice_fire = (ctrl.src == SRC_LATTICE) && out_free;

    assign pkind  = {1'b0, kind_reg};
    assign nb_sel = (pkind == KIND_MATRIX || pkind == KIND_TILTED) ? dim_b_reg
                                                                    : CNT_W'(1);

    // lattice walk
    assign row_end  = (j_reg == nb_reg - CNT_W'(1));
    assign lat_last = row_end && (i_reg == na_reg - CNT_W'(1));
    assign i_next   = row_end ? i_reg + CNT_W'(1) : i_reg;
    assign j_next   = row_end ? '0 : j_reg + CNT_W'(1);
    assign rd_idx   = lattice_fire ? i_next : i_reg;
    assign tab_ok   = (i_reg < CNT_W'(OFFSET_DEPTH));

    assign lat_x = pos_x_reg + ((tab_x_reg && tab_ok) ? ram_rdata[31:0]  : 32'd0);
    assign lat_y = pos_y_reg + ((tab_y_reg && tab_ok) ? ram_rdata[63:32] : 32'd0);

    assign ram_we = ctrl.decode && (in_reg.func == FUNC_LOAD)
                    && (in_reg.count_a < CNT_W'(OFFSET_DEPTH));

    lre_ram #(
        .WIDTH (64),
        .DEPTH (OFFSET_DEPTH)
    ) u_offset_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_reg.count_a[OFF_AW-1:0]),
        .wdata ({in_reg.coord_y, in_reg.coord_x}),
        .raddr (rd_idx[OFF_AW-1:0]),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        pc_next = pc_reg;
        unique case (ctrl.jmp)
            JMP_ALWAYS:
            begin
                pc_next = ctrl.target;
            end
            JMP_ON_IN:
            begin
                if (in_fire)
                begin
                    pc_next = ctrl.target;
                end
            end
            JMP_ON_FUNC:
            begin
                if (in_reg.func != FUNC_PLACE)
                begin
                    pc_next = PC_IDLE;
                end
                else if (in_reg.has_rep)
                begin
                    pc_next = PC_CHECK;
                end
                else
                begin
                    pc_next = PC_SINGLE;
                end
            end
            JMP_ON_CHECK:
            begin
                if (!desc_valid_reg || total_reg > TOTAL_W'(MAX_COPIES))
                begin
                    pc_next = PC_ERROR;
                end
                else if (total_reg == '0)
                begin
                    pc_next = PC_IDLE;
                end
                else
                begin
                    pc_next = PC_LATTICE;
                end
            end
            JMP_ON_OUT:
            begin
                if (out_free)
                begin
                    pc_next = ctrl.target;
                end
            end
            JMP_ON_LAST:
            begin
                if (out_free && lat_last)
                begin
                    pc_next = ctrl.target;
                end
            end
            default:
            begin
                pc_next = PC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_reg <= rect_word;
        end
    end

    // stored descriptor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= '0;
            desc_valid_reg <= 1'b0;
            dim_a_reg      <= '0;
            dim_b_reg      <= '0;
            step_a_x_reg   <= '0;
            step_a_y_reg   <= '0;
            step_b_x_reg   <= '0;
            step_b_y_reg   <= '0;
        end
        else if (ctrl.decode && in_reg.func == FUNC_DESC
                 && in_reg.rep_kind <= KIND_ARBITRARY)
        begin
            kind_reg       <= in_reg.rep_kind[2:0];
            desc_valid_reg <= 1'b1;
            dim_a_reg      <= in_reg.count_a;
            dim_b_reg      <= in_reg.count_b;
            step_a_x_reg   <= in_reg.coord_x;
            step_a_y_reg   <= in_reg.coord_y;
            step_b_x_reg   <= in_reg.second_x;
            step_b_y_reg   <= in_reg.second_y;
        end
    end

    // placement counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            na_reg    <= '0;
            nb_reg    <= '0;
            total_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else if (ctrl.decode && in_reg.func == FUNC_PLACE)
        begin
            na_reg    <= dim_a_reg;
            nb_reg    <= nb_sel;
            total_reg <= TOTAL_W'(dim_a_reg) * TOTAL_W'(nb_sel);
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else if (lattice_fire)
        begin
            i_reg <= i_next;
            j_reg <= j_next;
        end
    end

    // lattice datapath: outer and inner steps masked by kind
    always_ff @(posedge clk)
    begin
        if (ctrl.decode && in_reg.func == FUNC_PLACE)
        begin
            os_x_reg  <= (pkind == KIND_MATRIX || pkind == KIND_UNIF_X
                          || pkind == KIND_TILTED || pkind == KIND_DIAGONAL)
                         ? step_a_x_reg : 32'd0;
            os_y_reg  <= (pkind == KIND_UNIF_Y || pkind == KIND_TILTED
                          || pkind == KIND_DIAGONAL) ? step_a_y_reg : 32'd0;
            is_x_reg  <= (pkind == KIND_TILTED) ? step_b_x_reg : 32'd0;
            is_y_reg  <= (pkind == KIND_MATRIX) ? step_a_y_reg
                       : (pkind == KIND_TILTED) ? step_b_y_reg : 32'd0;
            tab_x_reg <= (pkind == KIND_VARY_X || pkind == KIND_ARBITRARY);
            tab_y_reg <= (pkind == KIND_VARY_Y || pkind == KIND_ARBITRARY);
            row_x_reg <= in_reg.coord_x;
            row_y_reg <= in_reg.coord_y;
            pos_x_reg <= in_reg.coord_x;
            pos_y_reg <= in_reg.coord_y;
        end
        else if (lattice_fire)
        begin
            if (row_end)
            begin
                row_x_reg <= row_x_reg + os_x_reg;
                row_y_reg <= row_y_reg + os_y_reg;
                pos_x_reg <= row_x_reg + os_x_reg;
                pos_y_reg <= row_y_reg + os_y_reg;
            end
            else
            begin
                pos_x_reg <= pos_x_reg + is_x_reg;
                pos_y_reg <= pos_y_reg + is_y_reg;
            end
        end
    end

    // output word register
    always_comb
    begin
        out_next = out_reg;
        case (ctrl.src)
            SRC_INPUT:
            begin
                out_next.out_x      = in_reg.coord_x;
                out_next.out_y      = in_reg.coord_y;
                out_next.out_width  = in_reg.rect_width;
                out_next.out_height = in_reg.rect_height;
                out_next.out_layer  = in_reg.layer_num;
                out_next.last       = 1'b1;
                out_next.error      = 1'b0;
            end
            SRC_ERROR:
            begin
                out_next       = '0;
                out_next.last  = 1'b1;
                out_next.error = 1'b1;
            end
            SRC_LATTICE:
            begin
                out_next.out_x      = lat_x;
                out_next.out_y      = lat_y;
                out_next.out_width  = in_reg.rect_width;
                out_next.out_height = in_reg.rect_height;
                out_next.out_layer  = in_reg.layer_num;
                out_next.last       = lat_last;
                out_next.error      = 1'b0;
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    assign out_valid_next = load_out ? 1'b1 : (copy_stall && out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign copy_valid = out_valid_reg;
    assign copy_word  = out_reg;

endmodule
`default_nettype wire

// File: design/lre_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lre_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: design/lre_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lre_checker
// Port-level checks for the layout repetition expander, bound to the top.
// ----------------------------------------------------------------------------
module lre_checker
    import lre_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      rect_valid,
    input wire logic      rect_stall,
    input wire in_word_t  rect_word,
    input wire logic      copy_valid,
    input wire logic      copy_stall,
    input wire out_word_t copy_word
);

    // stalled output word holds
    a_copy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        copy_valid && copy_stall |=> copy_valid && $stable(copy_word))
        else $error("copy word changed under stall");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        copy_valid && copy_word.error |-> copy_word.last)
        else $error("error word without last");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        copy_valid && copy_word.error |->
            copy_word.out_x == 0 && copy_word.out_y == 0
            && copy_word.out_width == 0 && copy_word.out_height == 0
            && copy_word.out_layer == 0)
        else $error("error word with nonzero fields");

    // a table load never produces a word
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        rect_valid && !rect_stall && rect_word.func == FUNC_LOAD
            |=> !$rose(copy_valid))
        else $error("word produced by table load");

endmodule

bind layout_repetition_expander_top lre_checker u_lre_checker (.*);
`default_nettype wire
